// ===== rtl/rrbb_pkg.sv =====
// Package for the rotated rectangle bounding box block.
// Holds the item payload type and the CORDIC arctangent table.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rrbb_pkg;

	typedef struct packed {
		logic               func;
		logic               fmt;
		logic               invx;
		logic               invy;
		logic signed [1:0]  cq;
		logic signed [1:0]  sq;
		logic [1:0]         quad;
		logic signed [32:0] l;
		logic signed [32:0] t;
		logic signed [32:0] r;
		logic signed [32:0] b;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} item_t;

	localparam logic signed [31:0] ATAN_UNITS [32] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

	localparam logic signed [30:0] CORDIC_START = 31'sd163008219;
	localparam logic signed [29:0] TRIG_ONE = 30'sd268435456;

endpackage
`default_nettype wire

// ===== rtl/rect_rotate_bounding_box.sv =====
// Top level of the rotated rectangle bounding box block.
// Holds the input fold, CORDIC stages, multiplier stages and bounding box stages.
// Depends on rrbb_pkg.
//
// Channel   Direction  Signals
// s_*       in         tvalid, tready, tdata (rectangle, angle, pivot), tuser (func)
// m_*       out        tvalid, tready, tdata (four result fields)
// cfg_*     in         we, wdata (rect_format)
//
// One item enters per cycle while the master side does not stall.
// Reset clears the valid bits and rect_format.
// A stall on the master side freezes every stage together; s_tready follows it.
`timescale 1ns / 1ps
`default_nettype none
module rect_rotate_bounding_box #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// quarter_turn, turn_angle, field_a, field_b, field_c, field_d, pivot_x, pivot_y
	input  wire logic [231:0] s_tdata,
	// func
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_a, out_b, out_c, out_d
	output logic [127:0]      m_tdata
);
	import rrbb_pkg::*;

	localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int N = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
	localparam logic signed [38:0] SAT_HI = (39'sd1 <<< (SAT_BITS - 1)) - 39'sd1;
	localparam logic signed [38:0] SAT_LO = -SAT_HI - 39'sd1;

	function automatic logic [31:0] sat(input logic signed [38:0] v);
		logic signed [38:0] o;
		begin
			o = v;
			if (v > SAT_HI) o = SAT_HI;
			if (v < SAT_LO) o = SAT_LO;
			return o[31:0];
		end
	endfunction

	function automatic logic signed [29:0] clamp(input logic signed [30:0] v);
		logic signed [29:0] o;
		begin
			o = v[29:0];
			if (v > 31'(TRIG_ONE)) o = TRIG_ONE;
			if (v < -31'(TRIG_ONE)) o = -TRIG_ONE;
			return o;
		end
	endfunction

	function automatic logic signed [35:0] sm(input logic signed [33:0] v,
			input logic signed [1:0] k);
		logic signed [35:0] e;
		begin
			e = {{2{v[33]}}, v};
			case (k)
				2'sb01: return e;
				2'sb11: return -e;
				default: return 36'sd0;
			endcase
		end
	endfunction

	logic en;
	logic rect_format_q;

	logic signed [31:0] fa, fb, fc, fd;
	logic [31:0] ang, asum;
	item_t in_it;
	logic [1:0] in_q;

	item_t             it_c [0:N];
	logic signed [30:0] x_c [0:N];
	logic signed [30:0] y_c [0:N];
	logic signed [31:0] z_c [0:N];
	logic               v_c [0:N];

	item_t it_m1;
	logic v_m1;
	logic signed [29:0] cs_m1, sn_m1;
	logic signed [33:0] dxl_m1, dxr_m1, dyt_m1, dyb_m1;
	logic signed [33:0] qdl_m1, qdr_m1, qdt_m1, qdb_m1, sx_m1, sy_m1;
	logic signed [29:0] cs_n, sn_n;

	item_t it_m2;
	logic v_m2;
	logic signed [63:0] pxc_m2 [2];
	logic signed [63:0] pxs_m2 [2];
	logic signed [63:0] pyc_m2 [2];
	logic signed [63:0] pys_m2 [2];
	logic signed [34:0] qnx_m2 [4];
	logic signed [34:0] qny_m2 [4];
	logic signed [34:0] qnx_n [4];
	logic signed [34:0] qny_n [4];

	item_t it_m3;
	logic v_m3;
	logic signed [35:0] ax_m3 [4];
	logic signed [35:0] ay_m3 [4];
	logic signed [34:0] qnx_m3 [4];
	logic signed [34:0] qny_m3 [4];
	logic signed [35:0] ax_n [4];
	logic signed [35:0] ay_n [4];

	item_t it_m4;
	logic v_m4;
	logic signed [36:0] nx_m4 [4];
	logic signed [36:0] ny_m4 [4];
	logic signed [36:0] nx_n [4];
	logic signed [36:0] ny_n [4];

	logic fmt_m5, invx_m5, invy_m5, v_m5;
	logic signed [36:0] minx_m5, maxx_m5, miny_m5, maxy_m5;
	logic signed [36:0] minx_n, maxx_n, miny_n, maxy_n;

	logic signed [38:0] ra, rb, rc, rd, wx, hy;
	logic v_m6;
	logic [127:0] data_m6;

	assign en = !v_m6 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_m6;
	assign m_tdata = data_m6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_format_q <= 1'b0;
		end else if (cfg_we) begin
			rect_format_q <= cfg_wdata;
		end
	end

	always_comb begin
		fa = $signed(s_tdata[66:35]);
		fb = $signed(s_tdata[98:67]);
		fc = $signed(s_tdata[130:99]);
		fd = $signed(s_tdata[162:131]);
		ang = s_tdata[34:3];
		asum = ang + 32'h2000_0000;
		in_q = asum[31:30];
		in_it.func = s_tuser;
		in_it.fmt = rect_format_q;
		in_it.quad = in_q;
		in_it.l = 33'(fa);
		in_it.t = 33'(fb);
		in_it.px = $signed(s_tdata[194:163]);
		in_it.py = $signed(s_tdata[226:195]);
		if (rect_format_q) begin
			in_it.r = 33'(fc);
			in_it.b = 33'(fd);
			in_it.invx = fa > fc;
			in_it.invy = fb > fd;
		end else begin
			in_it.r = 33'(fa) + 33'(fc);
			in_it.b = 33'(fb) + 33'(fd);
			in_it.invx = fc[31];
			in_it.invy = fd[31];
		end
		case (s_tdata[2:0])
			3'd0, 3'd5: begin
				in_it.cq = 2'sd0;
				in_it.sq = -2'sd1;
			end
			3'd1, 3'd4: begin
				in_it.cq = -2'sd1;
				in_it.sq = 2'sd0;
			end
			3'd2, 3'd3: begin
				in_it.cq = 2'sd0;
				in_it.sq = 2'sd1;
			end
			default: begin
				in_it.cq = 2'sd1;
				in_it.sq = 2'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (en) begin
			v_c[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_c[0] <= in_it;
			x_c[0] <= CORDIC_START;
			y_c[0] <= 31'sd0;
			z_c[0] <= $signed(ang - {in_q, 30'b0});
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_cordic
		logic signed [30:0] xs, ys;
		assign xs = x_c[g] >>> g;
		assign ys = y_c[g] >>> g;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[g+1] <= 1'b0;
			end else if (en) begin
				v_c[g+1] <= v_c[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_c[g+1] <= it_c[g];
				if (!z_c[g][31]) begin
					x_c[g+1] <= x_c[g] - ys;
					y_c[g+1] <= y_c[g] + xs;
					z_c[g+1] <= z_c[g] - ATAN_UNITS[g];
				end else begin
					x_c[g+1] <= x_c[g] + ys;
					y_c[g+1] <= y_c[g] - xs;
					z_c[g+1] <= z_c[g] + ATAN_UNITS[g];
				end
			end
		end
	end

	always_comb begin
		case (it_c[N].quad)
			2'd0: begin
				cs_n = clamp(x_c[N]);
				sn_n = clamp(y_c[N]);
			end
			2'd1: begin
				cs_n = -clamp(y_c[N]);
				sn_n = clamp(x_c[N]);
			end
			2'd2: begin
				cs_n = -clamp(x_c[N]);
				sn_n = -clamp(y_c[N]);
			end
			default: begin
				cs_n = clamp(y_c[N]);
				sn_n = -clamp(x_c[N]);
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qnx_n[k] = '0;
			qny_n[k] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			logic signed [33:0] qx, qy;
			logic signed [35:0] tx, ty;
			qx = (k == 1 || k == 2) ? qdr_m1 : qdl_m1;
			qy = (k >= 2) ? qdb_m1 : qdt_m1;
			tx = sm(qx, it_m1.cq) - sm(qy, it_m1.sq) + 36'(sx_m1) + 36'sd1;
			ty = sm(qx, it_m1.sq) + sm(qy, it_m1.cq) + 36'(sy_m1) + 36'sd1;
			qnx_n[k] = tx[35:1];
			qny_n[k] = ty[35:1];
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic signed [63:0] sx, sy;
			sx = pxc_m2[(k == 1 || k == 2) ? 1 : 0] - pys_m2[(k >= 2) ? 1 : 0]
				+ 64'sd134217728;
			sy = pxs_m2[(k == 1 || k == 2) ? 1 : 0] + pyc_m2[(k >= 2) ? 1 : 0]
				+ 64'sd134217728;
			ax_n[k] = sx[63:28];
			ay_n[k] = sy[63:28];
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (it_m3.func) begin
				nx_n[k] = 37'(ax_m3[k]) + 37'(it_m3.px);
				ny_n[k] = 37'(ay_m3[k]) + 37'(it_m3.py);
			end else begin
				nx_n[k] = 37'(qnx_m3[k]);
				ny_n[k] = 37'(qny_m3[k]);
			end
		end
	end

	always_comb begin
		logic signed [36:0] a0, a1, b0, b1, c0, c1, d0, d1;
		a0 = (nx_m4[0] < nx_m4[1]) ? nx_m4[0] : nx_m4[1];
		a1 = (nx_m4[2] < nx_m4[3]) ? nx_m4[2] : nx_m4[3];
		b0 = (nx_m4[0] > nx_m4[1]) ? nx_m4[0] : nx_m4[1];
		b1 = (nx_m4[2] > nx_m4[3]) ? nx_m4[2] : nx_m4[3];
		c0 = (ny_m4[0] < ny_m4[1]) ? ny_m4[0] : ny_m4[1];
		c1 = (ny_m4[2] < ny_m4[3]) ? ny_m4[2] : ny_m4[3];
		d0 = (ny_m4[0] > ny_m4[1]) ? ny_m4[0] : ny_m4[1];
		d1 = (ny_m4[2] > ny_m4[3]) ? ny_m4[2] : ny_m4[3];
		minx_n = (a0 < a1) ? a0 : a1;
		maxx_n = (b0 > b1) ? b0 : b1;
		miny_n = (c0 < c1) ? c0 : c1;
		maxy_n = (d0 > d1) ? d0 : d1;
	end

	always_comb begin
		wx = 39'(maxx_m5) - 39'(minx_m5);
		hy = 39'(maxy_m5) - 39'(miny_m5);
		ra = invx_m5 ? 39'(maxx_m5) : 39'(minx_m5);
		rb = invy_m5 ? 39'(maxy_m5) : 39'(miny_m5);
		if (fmt_m5) begin
			rc = invx_m5 ? 39'(minx_m5) : 39'(maxx_m5);
			rd = invy_m5 ? 39'(miny_m5) : 39'(maxy_m5);
		end else begin
			rc = invx_m5 ? -wx : wx;
			rd = invy_m5 ? -hy : hy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			v_m5 <= 1'b0;
			v_m6 <= 1'b0;
		end else if (en) begin
			v_m1 <= v_c[N];
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			v_m5 <= v_m4;
			v_m6 <= v_m5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_m1 <= it_c[N];
			cs_m1 <= cs_n;
			sn_m1 <= sn_n;
			dxl_m1 <= 34'(it_c[N].l) - 34'(it_c[N].px);
			dxr_m1 <= 34'(it_c[N].r) - 34'(it_c[N].px);
			dyt_m1 <= 34'(it_c[N].t) - 34'(it_c[N].py);
			dyb_m1 <= 34'(it_c[N].b) - 34'(it_c[N].py);
			qdl_m1 <= 34'(it_c[N].l) - 34'(it_c[N].r);
			qdr_m1 <= 34'(it_c[N].r) - 34'(it_c[N].l);
			qdt_m1 <= 34'(it_c[N].t) - 34'(it_c[N].b);
			qdb_m1 <= 34'(it_c[N].b) - 34'(it_c[N].t);
			sx_m1 <= 34'(it_c[N].l) + 34'(it_c[N].r);
			sy_m1 <= 34'(it_c[N].t) + 34'(it_c[N].b);

			it_m2 <= it_m1;
			pxc_m2[0] <= 64'(dxl_m1 * cs_m1);
			pxc_m2[1] <= 64'(dxr_m1 * cs_m1);
			pxs_m2[0] <= 64'(dxl_m1 * sn_m1);
			pxs_m2[1] <= 64'(dxr_m1 * sn_m1);
			pyc_m2[0] <= 64'(dyt_m1 * cs_m1);
			pyc_m2[1] <= 64'(dyb_m1 * cs_m1);
			pys_m2[0] <= 64'(dyt_m1 * sn_m1);
			pys_m2[1] <= 64'(dyb_m1 * sn_m1);
			qnx_m2 <= qnx_n;
			qny_m2 <= qny_n;

			it_m3 <= it_m2;
			ax_m3 <= ax_n;
			ay_m3 <= ay_n;
			qnx_m3 <= qnx_m2;
			qny_m3 <= qny_m2;

			it_m4 <= it_m3;
			nx_m4 <= nx_n;
			ny_m4 <= ny_n;

			fmt_m5 <= it_m4.fmt;
			invx_m5 <= it_m4.invx;
			invy_m5 <= it_m4.invy;
			minx_m5 <= minx_n;
			maxx_m5 <= maxx_n;
			miny_m5 <= miny_n;
			maxy_m5 <= maxy_n;

			data_m6 <= {sat(rd), sat(rc), sat(rb), sat(ra)};
		end
	end

endmodule
`default_nettype wire
